[rtl/stfs_pkg.sv]
// ============================================================================
// stfs_pkg
// Shared types and codes for the sorted tick floor search unit.
// ============================================================================
package stfs_pkg;

    // Command codes carried on the request channel.
    localparam logic [1:0] CMD_CLEAR  = 2'd0;
    localparam logic [1:0] CMD_APPEND = 2'd1;
    localparam logic [1:0] CMD_QUERY  = 2'd2;

    // Status codes carried on the response channel.
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;

    typedef struct packed {
        logic [1:0]         command;
        logic signed [63:0] tick_time;
        logic [31:0]        bid_bits;
        logic [31:0]        ask_bits;
        logic [31:0]        volume_bits;
        logic [7:0]         tick_flags;
    } req_item_t;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [63:0] found_time;
        logic [31:0]        found_bid;
        logic [31:0]        found_ask;
        logic [31:0]        found_volume;
        logic [7:0]         found_flags;
    } rsp_item_t;

    // One stored tick, as it sits in a table word.
    typedef struct packed {
        logic signed [63:0] tick_time;
        logic [31:0]        bid_bits;
        logic [31:0]        ask_bits;
        logic [31:0]        volume_bits;
        logic [7:0]         tick_flags;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

endpackage

[rtl/stfs_if.sv]
// ============================================================================
// stfs_if
// Valid/ready channels for the request and response sides.
// ============================================================================
interface stfs_req_if;
    import stfs_pkg::*;

    logic      valid;
    logic      ready;
    req_item_t item;

    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface

interface stfs_rsp_if;
    import stfs_pkg::*;

    logic      valid;
    logic      ready;
    rsp_item_t item;

    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface

[rtl/sorted_tick_floor_search_unit.sv]
// Clear, append and unknown commands: the response is valid one cycle after
// the request transfer. A query first reads entry zero, then runs P binary
// search probes with one table read per probe on the RAM port, where P is at
// most ceil(log2(entries + 1)). An empty table or an early query skips them.
// One item is in flight at a time; the next request is taken the cycle after
// the response transfer. Reset empties the table; stored words stay as they are.
// ============================================================================
// sorted_tick_floor_search_unit
// Tick table with append, clear and floor lookup by binary search.
// ============================================================================
module sorted_tick_floor_search_unit #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic       clk,
    input  logic       rst_n,
    stfs_req_if.sink   req,
    stfs_rsp_if.source rsp
);
    import stfs_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    // Sequencer states. IDLE takes a request, FIRST checks entry zero,
    // PROBE runs one search step per cycle, OUT holds the response.
    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_FIRST = 4'b0010,
        S_PROBE = 4'b0100,
        S_OUT   = 4'b1000
    } state_t;

    state_t    state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;

    // Search window is half open: [lo, hi). mid_reg is the entry being read.
    logic [CW-1:0]      lo_reg, lo_next;
    logic [CW-1:0]      hi_reg, hi_next;
    logic [AW-1:0]      mid_reg, mid_next;
    logic signed [63:0] qtime_reg, qtime_next;
    rsp_item_t          res_reg, res_next;

    logic               ram_we;
    logic [AW-1:0]      ram_raddr;
    logic [ENTRY_W-1:0] ram_rdata;
    entry_t             wr_entry;
    entry_t             rd_entry;
    logic               probe_le;
    logic [CW-1:0]      lo_step;
    logic [CW-1:0]      hi_step;

    // Midpoint of a nonempty window, rounded down as in lo + (hi_incl - lo) / 2.
    function automatic logic [AW-1:0] mid_of(input logic [CW-1:0] lo,
                                             input logic [CW-1:0] hi);
        logic [CW:0] sum;
        sum = {1'b0, lo} + {1'b0, hi} - {{CW{1'b0}}, 1'b1};
        return sum[AW:1];
    endfunction

    assign wr_entry.tick_time   = req.item.tick_time;
    assign wr_entry.bid_bits    = req.item.bid_bits;
    assign wr_entry.ask_bits    = req.item.ask_bits;
    assign wr_entry.volume_bits = req.item.volume_bits;
    assign wr_entry.tick_flags  = req.item.tick_flags;

    stfs_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (count_reg[AW-1:0]),
        .wdata (wr_entry),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_entry = entry_t'(ram_rdata);

    // The one shared comparator: is the entry just read at or before the
    // query time, as signed 64-bit values.
    assign probe_le = (rd_entry.tick_time <= qtime_reg);

    // Window after the current probe: go right past mid when the entry is at
    // or before the query time, else shrink the right edge to mid.
    always_comb
    begin
        if (probe_le)
        begin
            lo_step = CW'(mid_reg) + CW'(1);
            hi_step = hi_reg;
        end
        else
        begin
            lo_step = lo_reg;
            hi_step = CW'(mid_reg);
        end
    end

    assign req.ready = (state_reg == S_IDLE);
    assign rsp.valid = (state_reg == S_OUT);
    assign rsp.item  = res_reg;

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        mid_next   = mid_reg;
        qtime_next = qtime_reg;
        res_next   = res_reg;
        ram_we     = 1'b0;
        ram_raddr  = mid_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    res_next   = '0;
                    qtime_next = req.item.tick_time;
                    state_next = S_OUT;
                    unique case (req.item.command)
                        CMD_CLEAR:
                        begin
                            count_next      = '0;
                            res_next.status = ST_OK;
                        end
                        CMD_APPEND:
                        begin
                            if (count_reg == CW'(TABLE_DEPTH))
                            begin
                                res_next.status = ST_FULL;
                            end
                            else
                            begin
                                ram_we          = 1'b1;
                                count_next      = count_reg + CW'(1);
                                res_next.status = ST_OK;
                            end
                        end
                        CMD_QUERY:
                        begin
                            if (count_reg == '0)
                            begin
                                res_next.status = ST_NOT_FOUND;
                            end
                            else
                            begin
                                // Read entry zero first to rule out an early query.
                                ram_raddr  = '0;
                                state_next = S_FIRST;
                            end
                        end
                        default:
                        begin
                            res_next.status = ST_NOT_FOUND;
                        end
                    endcase
                end
            end

            S_FIRST:
            begin
                if (probe_le)
                begin
                    // Entry zero is the answer unless a later probe does better.
                    res_next.status       = ST_OK;
                    res_next.found_time   = rd_entry.tick_time;
                    res_next.found_bid    = rd_entry.bid_bits;
                    res_next.found_ask    = rd_entry.ask_bits;
                    res_next.found_volume = rd_entry.volume_bits;
                    res_next.found_flags  = rd_entry.tick_flags;
                    lo_next    = '0;
                    hi_next    = count_reg;
                    mid_next   = mid_of('0, count_reg);
                    ram_raddr  = mid_of('0, count_reg);
                    state_next = S_PROBE;
                end
                else
                begin
                    res_next.status = ST_NOT_FOUND;
                    state_next      = S_OUT;
                end
            end

            S_PROBE:
            begin
                if (probe_le)
                begin
                    res_next.found_time   = rd_entry.tick_time;
                    res_next.found_bid    = rd_entry.bid_bits;
                    res_next.found_ask    = rd_entry.ask_bits;
                    res_next.found_volume = rd_entry.volume_bits;
                    res_next.found_flags  = rd_entry.tick_flags;
                end
                lo_next = lo_step;
                hi_next = hi_step;
                if (lo_step < hi_step)
                begin
                    mid_next  = mid_of(lo_step, hi_step);
                    ram_raddr = mid_of(lo_step, hi_step);
                end
                else
                begin
                    state_next = S_OUT;
                end
            end

            S_OUT:
            begin
                if (rsp.ready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;
        mid_reg   <= mid_next;
        qtime_reg <= qtime_next;
        res_reg   <= res_next;
    end

endmodule

[rtl/stfs_ram.sv]
// ============================================================================
// stfs_ram
// Generic single-write, single-read RAM with a registered read port.
// ============================================================================
module stfs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[dv/tb_sorted_tick_floor_search_unit.sv]
// ============================================================================
// tb_sorted_tick_floor_search_unit
// Self-checking bench for the tick table. Clear, append and floor-lookup
// commands are streamed in over the request channel. A behavioral copy of the
// table predicts every response, and the response channel is checked against
// that prediction field by field. The sender and the receiver both stall at
// random.
// ============================================================================
module tb_sorted_tick_floor_search_unit;
    import stfs_pkg::*;

    localparam int TABLE_DEPTH = 1024;
    localparam int HOLD_CYCLES = 300;
    localparam int TAIL_CYCLES = 20;

    // The package has no name for the fourth command code, and the block
    // answers it with not found.
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    localparam longint TIME_MIN = 64'h8000_0000_0000_0000;
    localparam longint TIME_MAX = 64'h7FFF_FFFF_FFFF_FFFF;

    logic clk;
    logic rst_n;

    stfs_req_if req_ch ();
    stfs_rsp_if rsp_ch ();

    sorted_tick_floor_search_unit #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) dut (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (req_ch),
        .rsp  (rsp_ch)
    );

    // ------------------------------------------------------------------------
    // Behavioral tick table. It tracks the block's table through every
    // accepted request and produces the response that the block owes for it.
    // ------------------------------------------------------------------------
    longint      tbl_time   [TABLE_DEPTH];
    logic [31:0] tbl_bid    [TABLE_DEPTH];
    logic [31:0] tbl_ask    [TABLE_DEPTH];
    logic [31:0] tbl_volume [TABLE_DEPTH];
    logic [7:0]  tbl_flags  [TABLE_DEPTH];
    int          tbl_count = 0;

    // Requests waiting for the driver, and responses owed by the block in
    // the order in which their requests were transferred.
    req_item_t queued_commands[$];
    rsp_item_t awaited_responses[$];

    // Timestamps that the stimulus believes are in the table, used to aim
    // queries at stored ticks, at the gaps between them and at the edges.
    longint stim_times[$];

    int        queued_count = 0;
    int        src_idle_pct = 0;
    int        rsp_idle_pct = 0;
    bit        hold_go;
    int        hold_left;
    int        fail_count   = 0;
    rsp_item_t next_result;

    int n_clears   = 0;
    int n_appends  = 0;
    int n_dropped  = 0;
    int n_hits     = 0;
    int n_misses   = 0;
    int n_unused   = 0;

    // Applies one command to the table and returns the response it causes.
    // The lookup walks the stored order with midpoint probes, stepping right
    // when the probe is at or before the query time, so that a table with
    // out-of-order appends gives the same answer as the block.
    function automatic rsp_item_t apply_tick_command(req_item_t cmd);
        rsp_item_t res;
        longint    q_time;
        int        lo;
        int        hi;
        int        mid;
        int        hit;
        res    = '0;
        q_time = cmd.tick_time;
        case (cmd.command)
            CMD_CLEAR:
            begin
                tbl_count  = 0;
                res.status = ST_OK;
            end
            CMD_APPEND:
            begin
                if (tbl_count >= TABLE_DEPTH)
                begin
                    res.status = ST_FULL;
                end
                else
                begin
                    tbl_time[tbl_count]   = cmd.tick_time;
                    tbl_bid[tbl_count]    = cmd.bid_bits;
                    tbl_ask[tbl_count]    = cmd.ask_bits;
                    tbl_volume[tbl_count] = cmd.volume_bits;
                    tbl_flags[tbl_count]  = cmd.tick_flags;
                    tbl_count++;
                    res.status = ST_OK;
                end
            end
            CMD_QUERY:
            begin
                if (tbl_count == 0 || tbl_time[0] > q_time)
                begin
                    res.status = ST_NOT_FOUND;
                end
                else
                begin
                    lo  = 0;
                    hi  = tbl_count - 1;
                    hit = 0;
                    while (lo <= hi)
                    begin
                        mid = lo + (hi - lo) / 2;
                        if (tbl_time[mid] <= q_time)
                        begin
                            hit = mid;
                            lo  = mid + 1;
                        end
                        else
                        begin
                            hi = mid - 1;
                        end
                    end
                    res.status       = ST_OK;
                    res.found_time   = tbl_time[hit];
                    res.found_bid    = tbl_bid[hit];
                    res.found_ask    = tbl_ask[hit];
                    res.found_volume = tbl_volume[hit];
                    res.found_flags  = tbl_flags[hit];
                end
            end
            default:
            begin
                res.status = ST_NOT_FOUND;
            end
        endcase
        return res;
    endfunction

    task automatic compare_field(string field, logic [63:0] want, logic [63:0] got);
        if (want !== got)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
            fail_count++;
        end
    endtask

    // ------------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------------
    function automatic longint rand64();
        return longint'({$urandom, $urandom});
    endfunction

    // Adds an offset to a timestamp, pinned at the ends of the signed range.
    function automatic longint sat_add(longint base, longint delta);
        longint sum;
        sum = base + delta;
        if (delta > 0 && sum < base)
            sum = TIME_MAX;
        else if (delta < 0 && sum > base)
            sum = TIME_MIN;
        return sum;
    endfunction

    function automatic req_item_t tick_cmd(logic [1:0] op, longint stamp);
        req_item_t c;
        c.command     = op;
        c.tick_time   = stamp;
        c.bid_bits    = $urandom;
        c.ask_bits    = $urandom;
        c.volume_bits = $urandom;
        c.tick_flags  = 8'($urandom_range(255));
        return c;
    endfunction

    // Queues one request and keeps the stimulus view of the table in step.
    // The unused command code is not counted, since it leaves the table alone.
    task automatic queue_item(req_item_t c);
        queued_commands.insert(queued_commands.size(), c);
        if (c.command == CMD_CLEAR)
            stim_times.delete();
        else if (c.command == CMD_APPEND && stim_times.size() < TABLE_DEPTH)
            stim_times.insert(stim_times.size(), c.tick_time);
        if (c.command != CMD_UNUSED)
            queued_count++;
    endtask

    // Picks the time for the next in-order append. A fresh table starts near
    // either end of the range, around zero, or anywhere; later ticks step
    // forward by zero (a duplicate), a little, or a lot.
    function automatic longint next_append_time();
        int r;
        r = $urandom_range(99);
        if (stim_times.size() == 0)
        begin
            if (r < 15)
                return sat_add(TIME_MIN, longint'($urandom_range(50)));
            if (r < 30)
                return sat_add(TIME_MAX, -longint'($urandom_range(5000)));
            if (r < 70)
                return longint'($urandom_range(200000)) - 100000;
            return rand64();
        end
        if (r < 20)
            return stim_times[$];
        if (r < 85)
            return sat_add(stim_times[$], longint'($urandom_range(1, 1000)));
        return sat_add(stim_times[$], longint'($urandom));
    endfunction

    // Aims a query at a stored tick, near one, before the first, after the
    // last, at an end of the range, or anywhere at all.
    function automatic longint pick_query_time();
        int r;
        int idx;
        r = $urandom_range(99);
        if (stim_times.size() == 0 || r < 8)
            return rand64();
        idx = int'($urandom_range(stim_times.size() - 1));
        if (r < 40)
            return stim_times[idx];
        if (r < 75)
            return sat_add(stim_times[idx], longint'($urandom_range(2000)) - 1000);
        if (r < 85)
            return sat_add(stim_times[0], -1 - longint'($urandom_range(50)));
        if (r < 92)
            return sat_add(stim_times[$], longint'($urandom_range(100)));
        return ($urandom_range(1) != 0) ? TIME_MAX : TIME_MIN;
    endfunction

    // One session: a clear, then mostly in-order appends and lookups with
    // random content, with some noise mixed in (unused codes, out-of-order
    // appends and a clear in the middle).
    task automatic queue_session(int n_ops);
        int r;
        queue_item(tick_cmd(CMD_CLEAR, rand64()));
        for (int i = 0; i < n_ops; i++)
        begin
            r = $urandom_range(99);
            if (r < 45)
                queue_item(tick_cmd(CMD_APPEND, next_append_time()));
            else if (r < 88)
                queue_item(tick_cmd(CMD_QUERY, pick_query_time()));
            else if (r < 92)
                queue_item(tick_cmd(CMD_UNUSED, rand64()));
            else if (r < 97)
                queue_item(tick_cmd(CMD_APPEND, rand64()));
            else
                queue_item(tick_cmd(CMD_CLEAR, rand64()));
        end
    endtask

    // Returns once every queued request has been transferred and every
    // response has arrived. Sampling on the falling edge keeps clear of the
    // updates that the driver and the monitor make on the rising edge.
    task automatic wait_for_idle();
        do
            @(negedge clk);
        while (queued_commands.size() != 0 || req_ch.valid
               || awaited_responses.size() != 0);
    endtask

    // ------------------------------------------------------------------------
    // Clock.
    // ------------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Request driver. On a transfer the request goes through the behavioral
    // table and its response joins the list of awaited responses. A new
    // request is offered only when the current one has been taken, so valid
    // never drops while a request waits, and the item holds steady with it.
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_ch.valid <= 1'b0;
            req_ch.item  <= '0;
        end
        else
        begin
            if (req_ch.valid && req_ch.ready)
            begin
                next_result = apply_tick_command(req_ch.item);
                awaited_responses.insert(awaited_responses.size(), next_result);
                case (req_ch.item.command)
                    CMD_CLEAR:  n_clears++;
                    CMD_APPEND:
                    begin
                        if (next_result.status == ST_FULL)
                            n_dropped++;
                        else
                            n_appends++;
                    end
                    CMD_QUERY:
                    begin
                        if (next_result.status == ST_OK)
                            n_hits++;
                        else
                            n_misses++;
                    end
                    default:    n_unused++;
                endcase
            end
            if (!req_ch.valid || req_ch.ready)
            begin
                if (queued_commands.size() != 0 && $urandom_range(99) >= src_idle_pct)
                begin
                    req_ch.valid <= 1'b1;
                    req_ch.item  <= queued_commands.pop_front();
                end
                else
                begin
                    req_ch.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Response ready. A pulse on hold_go starts a long hold-off that this
    // process counts down; otherwise ready is dropped at random.
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
            hold_left    <= 0;
        end
        else if (hold_go)
        begin
            rsp_ch.ready <= 1'b0;
            hold_left    <= HOLD_CYCLES;
        end
        else if (hold_left != 0)
        begin
            rsp_ch.ready <= 1'b0;
            hold_left    <= hold_left - 1;
        end
        else
        begin
            rsp_ch.ready <= ($urandom_range(99) >= rsp_idle_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Response monitor. Every response transfer is matched against the
    // oldest awaited response.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (awaited_responses.size() == 0)
            begin
                $error("unexpected response transfer with status %0d", rsp_ch.item.status);
                fail_count++;
            end
            else
            begin
                next_expected_check: begin
                    rsp_item_t want;
                    want = awaited_responses.pop_front();
                    compare_field("status",       want.status,       rsp_ch.item.status);
                    compare_field("found_time",   want.found_time,   rsp_ch.item.found_time);
                    compare_field("found_bid",    want.found_bid,    rsp_ch.item.found_bid);
                    compare_field("found_ask",    want.found_ask,    rsp_ch.item.found_ask);
                    compare_field("found_volume", want.found_volume, rsp_ch.item.found_volume);
                    compare_field("found_flags",  want.found_flags,  rsp_ch.item.found_flags);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Test sequence.
    // ------------------------------------------------------------------------
    initial
    begin
        req_item_t c;

        rst_n        = 1'b0;
        hold_go      = 1'b0;
        src_idle_pct = 23;
        rsp_idle_pct = 77;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Directed checks. A lookup on the empty table after reset, and the
        // unused command code.
        queue_item(tick_cmd(CMD_QUERY, 0));
        queue_item(tick_cmd(CMD_UNUSED, rand64()));

        // The most negative timestamp with an all-ones payload, then -1 with an
        // all-zero payload, 0, a duplicate 0 and the largest time.
        c             = tick_cmd(CMD_APPEND, TIME_MIN);
        c.bid_bits    = '1;
        c.ask_bits    = '1;
        c.volume_bits = '1;
        c.tick_flags  = '1;
        queue_item(c);
        queue_item(tick_cmd(CMD_QUERY, TIME_MIN));
        c             = tick_cmd(CMD_APPEND, -1);
        c.bid_bits    = '0;
        c.ask_bits    = '0;
        c.volume_bits = '0;
        c.tick_flags  = '0;
        queue_item(c);
        queue_item(tick_cmd(CMD_APPEND, 0));
        queue_item(tick_cmd(CMD_APPEND, 0));
        queue_item(tick_cmd(CMD_APPEND, TIME_MAX));

        // Lookups at the top end, on the duplicates and right beside them.
        queue_item(tick_cmd(CMD_QUERY, TIME_MAX));
        queue_item(tick_cmd(CMD_QUERY, 0));
        queue_item(tick_cmd(CMD_QUERY, -1));
        queue_item(tick_cmd(CMD_QUERY, 1));

        // The unused code with an all-ones payload must leave the table
        // alone; a clear with an all-ones payload must not.
        c             = tick_cmd(CMD_UNUSED, -1);
        c.bid_bits    = '1;
        c.ask_bits    = '1;
        c.volume_bits = '1;
        c.tick_flags  = '1;
        queue_item(c);
        queue_item(tick_cmd(CMD_QUERY, TIME_MAX));
        c.command = CMD_CLEAR;
        queue_item(c);
        queue_item(tick_cmd(CMD_QUERY, 0));

        // A query time before the first tick, and an out-of-order append
        // that the search walks past in stored order.
        queue_item(tick_cmd(CMD_APPEND, 100));
        queue_item(tick_cmd(CMD_QUERY, 99));
        queue_item(tick_cmd(CMD_QUERY, 100));
        queue_item(tick_cmd(CMD_APPEND, 50));
        queue_item(tick_cmd(CMD_QUERY, 75));
        queue_item(tick_cmd(CMD_QUERY, TIME_MIN));
        queue_item(tick_cmd(CMD_CLEAR, 0));

        // Random sessions with a slow-ish sender and a much slower receiver.
        while (queued_count < 190)
            queue_session($urandom_range(4, 40));
        wait_for_idle();

        // The receiver holds off for a long stretch while the sender keeps
        // offering requests, so the block holds a response and stalls its input.
        @(negedge clk);
        hold_go = 1'b1;
        queue_session(12);
        @(negedge clk);
        hold_go = 1'b0;
        wait_for_idle();

        // The same kind of traffic with the idling swapped around.
        src_idle_pct = 77;
        rsp_idle_pct = 23;
        while (queued_count < 360)
            queue_session($urandom_range(4, 40));
        wait_for_idle();

        // Back-to-back traffic on both sides.
        src_idle_pct = 0;
        rsp_idle_pct = 0;
        while (queued_count < 505)
            queue_session($urandom_range(4, 40));

        // Build a deeper table with lookups along the way, look up across
        // it, then empty it again.
        queue_item(tick_cmd(CMD_CLEAR, rand64()));
        for (int i = 0; i < 96; i++)
        begin
            queue_item(tick_cmd(CMD_APPEND, next_append_time()));
            if (i % 16 == 15)
                queue_item(tick_cmd(CMD_QUERY, pick_query_time()));
        end
        for (int i = 0; i < 12; i++)
            queue_item(tick_cmd(CMD_QUERY, pick_query_time()));
        queue_item(tick_cmd(CMD_QUERY, TIME_MAX));
        queue_item(tick_cmd(CMD_CLEAR, rand64()));
        queue_item(tick_cmd(CMD_QUERY, TIME_MAX));
        wait_for_idle();

        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Run summary: %0d clears, %0d appends stored, %0d appends dropped on a full table.",
                 n_clears, n_appends, n_dropped);
        $display("Run summary: %0d lookups found, %0d not found, %0d unused command codes.",
                 n_hits, n_misses, n_unused);
        if (fail_count == 0 && awaited_responses.size() == 0)
            $display("sorted_tick_floor_search_unit: match");
        else
            $display("sorted_tick_floor_search_unit: mismatch");
        $finish;
    end

    // A stuck handshake ends the run as a failure.
    initial
    begin
        #4000000;
        $display("sorted_tick_floor_search_unit: mismatch");
        $finish;
    end

endmodule

[sim.f]
rtl/stfs_pkg.sv
rtl/stfs_if.sv
rtl/stfs_ram.sv
rtl/sorted_tick_floor_search_unit.sv
dv/tb_sorted_tick_floor_search_unit.sv
